[rtl/mlld_pkg.sv]
// Package: shared types, constants and helpers of the magic-or-line deframer.
`default_nettype none
package mlld_pkg;

  localparam logic [31:0] MagicWord     = 32'hDEAD_BEEF;
  localparam logic [7:0]  LineEnd       = 8'h0A;
  localparam logic [31:0] MaxLenReset   = 32'd8388576;

  localparam int unsigned MaxRes        = 4;
  localparam int unsigned ResCntW       = 3;
  localparam int unsigned ResQDepth     = 8;
  localparam int unsigned ResQPtrW      = 3;
  localparam int unsigned ResQCntW      = 4;

  localparam logic [1:0]  ErrNone       = 2'd0;
  localparam logic [1:0]  ErrBadLen     = 2'd1;
  localparam logic [1:0]  ErrLineLong   = 2'd2;

  localparam logic        KindText      = 1'b0;
  localparam logic        KindBin       = 1'b1;

  typedef enum logic [4:0] {
    PhOpen = 5'b00001,
    PhText = 5'b00010,
    PhLen  = 5'b00100,
    PhData = 5'b01000,
    PhDead = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       frame_kind;
    logic       frame_end;
    logic [1:0] err_code;
  } res_t;

  typedef struct packed {
    logic [ResCntW-1:0]    cnt;
    res_t [MaxRes-1:0]     res;
  } push_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] k);
    logic [7:0] b;
    unique case (k)
      2'd0:    b = MagicWord[31:24];
      2'd1:    b = MagicWord[23:16];
      2'd2:    b = MagicWord[15:8];
      default: b = MagicWord[7:0];
    endcase
    return b;
  endfunction

  function automatic res_t mk_res(input logic [7:0] b, input logic vld, input logic kind,
                                  input logic fend, input logic [1:0] err);
    res_t r;
    r.payload_byte = b;
    r.byte_valid   = vld;
    r.frame_kind   = kind;
    r.frame_end    = fend;
    r.err_code     = err;
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/mlld_in_if.sv]
// Interface: input byte channel.
`default_nettype none
interface mlld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

[rtl/mlld_out_if.sv]
// Interface: result channel.
`default_nettype none
interface mlld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       byte_valid;
  logic       frame_kind;
  logic       frame_end;
  logic [1:0] err_code;

  modport source (output valid, output payload_byte, output byte_valid, output frame_kind,
                  output frame_end, output err_code, input ready);
  modport sink   (input valid, input payload_byte, input byte_valid, input frame_kind,
                  input frame_end, input err_code, output ready);
endinterface
`default_nettype wire

[rtl/mlld_cfg_if.sv]
// Interface: configuration write channel for the payload length limit.
`default_nettype none
interface mlld_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] max_payload_len;

  modport source (output valid, output max_payload_len, input ready);
  modport sink   (input valid, input max_payload_len, output ready);
endinterface
`default_nettype wire

[rtl/mlld_core.sv]
// Input register, frame state and per-byte result generation.
`default_nettype none
module mlld_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  mlld_in_if.sink             in_chan,
  input  wire logic [31:0]    max_len_i,
  input  wire logic           room_i,
  output mlld_pkg::push_t     push_o
);

  logic                   in_vld_q;
  logic [7:0]             byte_q;
  logic                   adv;

  mlld_pkg::phase_e       phase_q, phase_d;
  logic [1:0]             mc_q, mc_d;
  logic [1:0]             lbs_q, lbs_d;
  logic [31:0]            acc_q, acc_d;
  logic [31:0]            bc_q, bc_d;

  mlld_pkg::res_t [mlld_pkg::MaxRes-1:0] res;
  logic [mlld_pkg::ResCntW-1:0]          n;
  logic                   do_text;
  logic [31:0]            tcnt;
  logic [31:0]            acc_dec;

  assign adv           = in_vld_q && room_i;
  assign in_chan.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_chan.valid && in_chan.ready) begin
      byte_q <= in_chan.data_byte;
    end
  end

  always_comb begin
    phase_d = phase_q;
    mc_d    = mc_q;
    lbs_d   = lbs_q;
    acc_d   = acc_q;
    bc_d    = bc_q;
    res     = '0;
    n       = '0;
    do_text = 1'b0;
    tcnt    = bc_q;
    acc_dec = (acc_q != 32'd0) ? acc_q - 32'd1 : 32'd0;
    unique case (phase_q)
      mlld_pkg::PhOpen: begin
        if (byte_q == mlld_pkg::magic_byte(mc_q)) begin
          if (mc_q == 2'd3) begin
            phase_d = mlld_pkg::PhLen;
            mc_d    = 2'd0;
            lbs_d   = 2'd0;
            acc_d   = 32'd0;
          end else begin
            mc_d = mc_q + 2'd1;
          end
        end else begin
          // held magic bytes turn into text
          mc_d = 2'd0;
          for (int k = 0; k < 3; k++) begin
            if ((2'(k) < mc_q) && (32'(k) < max_len_i)) begin
              res[n[1:0]] = mlld_pkg::mk_res(mlld_pkg::magic_byte(2'(k)), 1'b1,
                                             mlld_pkg::KindText, 1'b0, mlld_pkg::ErrNone);
              n = n + 3'd1;
            end
          end
          if (max_len_i < 32'(mc_q)) begin
            res[n[1:0]] = mlld_pkg::mk_res(8'h00, 1'b0, mlld_pkg::KindText, 1'b1,
                                           mlld_pkg::ErrLineLong);
            n       = n + 3'd1;
            phase_d = mlld_pkg::PhDead;
            mc_d    = mc_q;
          end else begin
            phase_d = mlld_pkg::PhText;
            do_text = 1'b1;
            tcnt    = 32'(mc_q);
          end
        end
      end
      mlld_pkg::PhText: begin
        do_text = 1'b1;
      end
      mlld_pkg::PhLen: begin
        acc_d = {acc_q[23:0], byte_q};
        if (lbs_q == 2'd3) begin
          lbs_d = 2'd0;
          if ((acc_d == 32'd0) || (acc_d > max_len_i)) begin
            res[n[1:0]] = mlld_pkg::mk_res(8'h00, 1'b0, mlld_pkg::KindBin, 1'b1,
                                           mlld_pkg::ErrBadLen);
            n       = n + 3'd1;
            phase_d = mlld_pkg::PhDead;
          end else begin
            phase_d = mlld_pkg::PhData;
          end
        end else begin
          lbs_d = lbs_q + 2'd1;
        end
      end
      mlld_pkg::PhData: begin
        res[n[1:0]] = mlld_pkg::mk_res(byte_q, 1'b1, mlld_pkg::KindBin, 1'b0,
                                       mlld_pkg::ErrNone);
        n     = n + 3'd1;
        acc_d = acc_dec;
        if (acc_dec == 32'd0) begin
          res[n[1:0]] = mlld_pkg::mk_res(8'h00, 1'b0, mlld_pkg::KindBin, 1'b1,
                                         mlld_pkg::ErrNone);
          n       = n + 3'd1;
          phase_d = mlld_pkg::PhOpen;
          mc_d    = 2'd0;
        end
      end
      mlld_pkg::PhDead: begin
        phase_d = mlld_pkg::PhDead;
      end
      default: begin
        phase_d = mlld_pkg::PhDead;
      end
    endcase

    if (do_text) begin
      if (byte_q == mlld_pkg::LineEnd) begin
        res[n[1:0]] = mlld_pkg::mk_res(8'h00, 1'b0, mlld_pkg::KindText, 1'b1,
                                       mlld_pkg::ErrNone);
        n       = n + 3'd1;
        phase_d = mlld_pkg::PhOpen;
        mc_d    = 2'd0;
        bc_d    = 32'd0;
      end else if (tcnt >= max_len_i) begin
        res[n[1:0]] = mlld_pkg::mk_res(8'h00, 1'b0, mlld_pkg::KindText, 1'b1,
                                       mlld_pkg::ErrLineLong);
        n       = n + 3'd1;
        phase_d = mlld_pkg::PhDead;
        bc_d    = tcnt;
      end else begin
        res[n[1:0]] = mlld_pkg::mk_res(byte_q, 1'b1, mlld_pkg::KindText, 1'b0,
                                       mlld_pkg::ErrNone);
        n       = n + 3'd1;
        bc_d    = tcnt + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mlld_pkg::PhOpen;
      mc_q    <= 2'd0;
      lbs_q   <= 2'd0;
      acc_q   <= 32'd0;
      bc_q    <= 32'd0;
    end else if (adv) begin
      phase_q <= phase_d;
      mc_q    <= mc_d;
      lbs_q   <= lbs_d;
      acc_q   <= acc_d;
      bc_q    <= bc_d;
    end
  end

  assign push_o.cnt = adv ? n : '0;
  assign push_o.res = res;

`ifndef SYNTHESIS
  a_dead_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == mlld_pkg::PhDead |=> phase_q == mlld_pkg::PhDead)
    else $error("closed session reopened");

  a_data_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == mlld_pkg::PhData |-> acc_q != 32'd0)
    else $error("payload phase with zero remaining length");

  a_close_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && phase_d == mlld_pkg::PhDead && phase_q != mlld_pkg::PhDead) |-> push_o.cnt != '0)
    else $error("session closed without an error result");
`endif

endmodule
`default_nettype wire

[rtl/mlld_resq.sv]
// Result queue: takes up to four results per cycle, returns one per transfer.
`default_nettype none
module mlld_resq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mlld_pkg::push_t push_i,
  output logic                room_o,
  mlld_out_if.source          out_chan
);

  mlld_pkg::res_t               mem [mlld_pkg::ResQDepth];
  logic [mlld_pkg::ResQPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [mlld_pkg::ResQCntW-1:0] count_q;
  logic                          pop;
  mlld_pkg::res_t                head;

  assign pop    = out_chan.valid && out_chan.ready;
  assign room_o = count_q <= mlld_pkg::ResQCntW'(mlld_pkg::ResQDepth - mlld_pkg::MaxRes);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < mlld_pkg::MaxRes; i++) begin
      if (mlld_pkg::ResCntW'(i) < push_i.cnt) begin
        mem[mlld_pkg::ResQPtrW'(wr_ptr_q + mlld_pkg::ResQPtrW'(i))] <= push_i.res[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= mlld_pkg::ResQPtrW'(wr_ptr_q + mlld_pkg::ResQPtrW'(push_i.cnt));
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= mlld_pkg::ResQCntW'(count_q + mlld_pkg::ResQCntW'(push_i.cnt)
                 - mlld_pkg::ResQCntW'(pop));
    end
  end

  assign head                  = mem[rd_ptr_q];
  assign out_chan.valid        = count_q != '0;
  assign out_chan.payload_byte = head.payload_byte;
  assign out_chan.byte_valid   = head.byte_valid;
  assign out_chan.frame_kind   = head.frame_kind;
  assign out_chan.frame_end    = head.frame_end;
  assign out_chan.err_code     = head.err_code;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= mlld_pkg::ResQCntW'(mlld_pkg::ResQDepth))
    else $error("result queue overflow");

  a_push_with_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != '0 |-> room_o)
    else $error("push without room");

  a_head_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop |=> rd_ptr_q == $past(rd_ptr_q))
    else $error("read pointer moved without a transfer");
`endif

endmodule
`default_nettype wire

[rtl/magic_length_or_line_deframer_unit.sv]
// Top level of the magic-or-line deframer: limit register, core and result queue.
//
//  channel   dir  payload                                                  when
//  in_chan   in   data_byte                                                valid & ready
//  out_chan  out  payload_byte byte_valid frame_kind frame_end err_code    valid & ready
//  cfg_chan  in   max_payload_len                                          valid & ready
//
// One byte per cycle enters the input register; the core then produces 0 to 4 results
// at once into an 8-entry result queue, which returns one result per transfer.
// Rate is one byte per cycle while the output is ready and each byte yields at most
// one result; a byte that ends a binary frame or breaks off a partial magic word costs
// extra output cycles. Input stalls only when the queue cannot hold four more results.
// Reset clears frame state and the queue and sets the limit to 8388576; no clearing pass.
`default_nettype none
module magic_length_or_line_deframer_unit (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mlld_in_if.sink     in_chan,
  mlld_out_if.source  out_chan,
  mlld_cfg_if.sink    cfg_chan
);

  logic [31:0]      max_len_q;
  logic             room;
  mlld_pkg::push_t  push;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= mlld_pkg::MaxLenReset;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      max_len_q <= cfg_chan.max_payload_len;
    end
  end

  mlld_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_chan   (in_chan),
    .max_len_i (max_len_q),
    .room_i    (room),
    .push_o    (push)
  );

  mlld_resq u_resq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .room_o   (room),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire
